@@ src/level_to_segment_serial_tx_defines.svh @@
// Assertion helpers for the segment-display serial transmitter.
`ifndef LEVEL_TO_SEGMENT_SERIAL_TX_DEFINES_SVH
`define LEVEL_TO_SEGMENT_SERIAL_TX_DEFINES_SVH

// Implication checked on every rising edge of clk_i, off while in reset.
`define L2STX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

@@ src/l2stx_pkg.sv @@
`default_nettype none

package l2stx_pkg;

  localparam int unsigned MvW      = 12;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned FrameCntW = 3;
  localparam int unsigned ByteQW   = 32;

  typedef enum logic [1:0] {
    MODE_SHOW,
    MODE_CLEAR,
    MODE_BRIGHT
  } mode_e;

  localparam logic [CfgIdxW-1:0] REG_BAND1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BAND2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BAND3 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BAND4 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TOP   = 3'd4;

  localparam logic [7:0] CMD_DISPLAY = 8'h08;
  localparam logic [7:0] CMD_BRIGHT  = 8'h18;

  typedef struct packed {
    logic [MvW-1:0] band1;
    logic [MvW-1:0] band2;
    logic [MvW-1:0] band3;
    logic [MvW-1:0] band4;
    logic [MvW-1:0] top;
  } cfg_t;

  // Bytes go out from the low end first.
  typedef struct packed {
    logic                 load;
    logic [FrameCntW-1:0] nframes;
    logic [ByteQW-1:0]    bytes;
  } load_t;

  function automatic logic [ByteQW-1:0] band_bytes(input logic [2:0] band);
    logic [ByteQW-1:0] b;
    unique case (band)
      3'd0:    b = {8'h3F, 8'h00, 8'h00, CMD_DISPLAY};
      3'd1:    b = {8'h6D, 8'h5B, 8'h00, CMD_DISPLAY};
      3'd2:    b = {8'h3F, 8'h6D, 8'h00, CMD_DISPLAY};
      3'd3:    b = {8'h6D, 8'h07, 8'h00, CMD_DISPLAY};
      default: b = {8'h3F, 8'h3F, 8'h06, CMD_DISPLAY};
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bright_code(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'hF0;
      3'd1:    c = 8'hF8;
      3'd2:    c = 8'hF4;
      3'd3:    c = 8'hFC;
      3'd4:    c = 8'hF2;
      3'd5:    c = 8'hFA;
      3'd6:    c = 8'hF6;
      default: c = 8'hFE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/l2stx_dec.sv @@
`default_nettype none

module l2stx_dec
  import l2stx_pkg::*;
(
  input  wire logic                valid_i,
  input  wire logic [1:0]          mode_i,
  input  wire logic [MvW-1:0]      sample_mv_i,
  input  wire logic [LevelW-1:0]   level_i,
  input  wire cfg_t                cfg_i,
  output load_t                    load_o
);

  logic [2:0] band;
  logic       band_ok;
  logic [2:0] lvl_m1;

  always_comb begin
    band    = 3'd0;
    band_ok = 1'b1;
    priority if (sample_mv_i < cfg_i.band1) begin
      band = 3'd0;
    end else if (sample_mv_i < cfg_i.band2) begin
      band = 3'd1;
    end else if (sample_mv_i < cfg_i.band3) begin
      band = 3'd2;
    end else if (sample_mv_i < cfg_i.band4) begin
      band = 3'd3;
    end else if (sample_mv_i <= cfg_i.top) begin
      band = 3'd4;
    end else begin
      band_ok = 1'b0;
    end
  end

  // level 8 wraps to index 7
  assign lvl_m1 = level_i[2:0] - 3'd1;

  always_comb begin
    load_o.load    = valid_i;
    load_o.nframes = '0;
    load_o.bytes   = '0;
    unique case (mode_i)
      MODE_SHOW: begin
        load_o.nframes = band_ok ? FrameCntW'(4) : '0;
        load_o.bytes   = band_bytes(band);
      end
      MODE_CLEAR: begin
        load_o.nframes = FrameCntW'(4);
        load_o.bytes   = {24'h0, CMD_DISPLAY};
      end
      MODE_BRIGHT: begin
        if (level_i >= LevelW'(1) && level_i <= LevelW'(8)) begin
          load_o.nframes = FrameCntW'(2);
        end else begin
          load_o.nframes = FrameCntW'(1);
        end
        load_o.bytes = {16'h0, bright_code(lvl_m1), CMD_BRIGHT};
      end
      default: begin
        load_o.nframes = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/l2stx_ser.sv @@
`default_nettype none

module l2stx_ser
  import l2stx_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire load_t load_i,
  output logic       busy_o,
  output logic       bit_valid_o,
  input  wire logic  bit_ready_i,
  output logic       bit_o,
  output logic       last_o
);

  localparam logic [3:0] BitStart  = 4'd0;
  localparam logic [3:0] BitParity = 4'd9;
  localparam logic [3:0] BitStop   = 4'd10;

  logic                 active_q, active_d;
  logic [FrameCntW-1:0] frames_q, frames_d;
  logic [ByteQW-1:0]    bytes_q, bytes_d;
  logic [3:0]           bitcnt_q, bitcnt_d;
  logic                 par_q, par_d;
  logic                 ovalid_q, ovalid_d;
  logic                 obit_q, obit_d;
  logic                 olast_q, olast_d;
  logic                 adv;
  logic                 cur_bit;

  assign adv = active_q && (!ovalid_q || bit_ready_i);

  always_comb begin
    active_d = active_q;
    frames_d = frames_q;
    bytes_d  = bytes_q;
    bitcnt_d = bitcnt_q;
    par_d    = par_q;
    ovalid_d = ovalid_q;
    obit_d   = obit_q;
    olast_d  = olast_q;
    cur_bit  = 1'b1;

    priority if (bitcnt_q == BitStart) begin
      cur_bit = 1'b0;
    end else if (bitcnt_q == BitParity) begin
      cur_bit = ~par_q;
    end else if (bitcnt_q == BitStop) begin
      cur_bit = 1'b1;
    end else begin
      cur_bit = bytes_q[0];
    end

    if (bit_ready_i) begin
      ovalid_d = 1'b0;
    end

    if (adv) begin
      ovalid_d = 1'b1;
      obit_d   = cur_bit;
      olast_d  = (bitcnt_q == BitStop) && (frames_q == FrameCntW'(1));
      if (bitcnt_q == BitStart) begin
        par_d    = 1'b0;
        bitcnt_d = bitcnt_q + 4'd1;
      end else if (bitcnt_q == BitStop) begin
        bitcnt_d = BitStart;
        frames_d = frames_q - FrameCntW'(1);
        if (frames_q == FrameCntW'(1)) begin
          active_d = 1'b0;
        end
      end else if (bitcnt_q == BitParity) begin
        bitcnt_d = bitcnt_q + 4'd1;
      end else begin
        par_d    = par_q ^ bytes_q[0];
        bytes_d  = {1'b0, bytes_q[ByteQW-1:1]};
        bitcnt_d = bitcnt_q + 4'd1;
      end
    end

    if (load_i.load && !active_q) begin
      active_d = (load_i.nframes != '0);
      frames_d = load_i.nframes;
      bytes_d  = load_i.bytes;
      bitcnt_d = BitStart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      frames_q <= '0;
      bitcnt_q <= BitStart;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      frames_q <= frames_d;
      bitcnt_q <= bitcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    par_q   <= par_d;
    obit_q  <= obit_d;
    olast_q <= olast_d;
  end

  assign busy_o      = active_q;
  assign bit_valid_o = ovalid_q;
  assign bit_o       = obit_q;
  assign last_o      = olast_q;

endmodule

`default_nettype wire

@@ src/level_to_segment_serial_tx.sv @@
// Serial transmitter for a segment-display controller. Each input word is one
// command (show level, clear, set brightness); the block answers with one
// output word per serial bit time, 11 bits per byte frame (start 0, eight
// data bits LSB first, odd parity, stop 1), tlast on the final stop bit.
// A command yields 0, 11, 22 or 44 bit words. The bit serializer emits one
// bit per cycle while the output side takes them; the next command is
// accepted in the cycle after its last bit has entered the output register.
// Commands that send nothing leave the block ready. The user must write
// thresholds through the cfg port only while no command is in flight; the
// block itself does not enforce this.
`default_nettype none
`include "level_to_segment_serial_tx_defines.svh"

module level_to_segment_serial_tx
  import l2stx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [MvW-1:0]     cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // [1:0] mode, [13:2] sample_mv, [17:14] brightness_level, [23:18] zero
  input  wire logic [23:0]        s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [0] line_level, [7:1] zero
  output logic [7:0]              m_axis_tdata,
  output logic                    m_axis_tlast
);

  cfg_t  cfg_q;
  load_t load;
  logic  busy;
  logic  accept;
  logic  line_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band1 <= MvW'(230);
      cfg_q.band2 <= MvW'(660);
      cfg_q.band3 <= MvW'(1000);
      cfg_q.band4 <= MvW'(1440);
      cfg_q.top   <= MvW'(1586);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BAND1: cfg_q.band1 <= cfg_data_i;
        REG_BAND2: cfg_q.band2 <= cfg_data_i;
        REG_BAND3: cfg_q.band3 <= cfg_data_i;
        REG_BAND4: cfg_q.band4 <= cfg_data_i;
        REG_TOP:   cfg_q.top   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  l2stx_dec u_dec (
    .valid_i     (accept),
    .mode_i      (s_axis_tdata[1:0]),
    .sample_mv_i (s_axis_tdata[13:2]),
    .level_i     (s_axis_tdata[17:14]),
    .cfg_i       (cfg_q),
    .load_o      (load)
  );

  l2stx_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .busy_o      (busy),
    .bit_valid_o (m_axis_tvalid),
    .bit_ready_i (m_axis_tready),
    .bit_o       (line_bit),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, line_bit};

  `L2STX_ASSERT(a_load_starts, (accept && load.nframes != '0) |=> busy, "command with frames did not start")
  `L2STX_ASSERT(a_empty_cmd_idle, (accept && load.nframes == '0) |=> s_axis_tready, "empty command left block busy")
  `L2STX_ASSERT(a_last_is_stop, (m_axis_tvalid && m_axis_tlast) |-> line_bit, "final bit is not a stop bit")
  `L2STX_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(line_bit) && $stable(m_axis_tlast)), "output word changed while stalled")

endmodule

`default_nettype wire
